// ----- src/ecg_morphological_extremum_detector_macros.svh -----
// Assertion macros for the ECG extremum detector.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ECG_MORPHOLOGICAL_EXTREMUM_DETECTOR_MACROS_SVH
`define ECG_MORPHOLOGICAL_EXTREMUM_DETECTOR_MACROS_SVH

// clocked check, off while reset is asserted
`define EMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define EMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/emd_pkg.sv -----
// Package for the ECG extremum detector: defaults, widths, codes, states.
// No dependencies.
`default_nettype none

package emd_pkg;

  localparam int STORE_DEPTH_D = 256;
  localparam int RING_DEPTH_D  = 64;
  localparam int HALF_WINDOW_D = 8;
  localparam int LOOK_BACK_D   = 16;
  localparam int LAP_MODULUS_D = 16;

  localparam int SAMPLE_W = 12;
  localparam int THR_W    = 13;
  localparam int XF_W     = 14;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 8;
  localparam int LAP_W    = 4;
  localparam int SLOT_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [THR_W-1:0] PEAK_THR_RST = 13'd140;
  localparam logic [THR_W-1:0] WAVE_THR_RST = 13'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_THR = 2'd1;

  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LEARN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_READY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_XFORM,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

// ----- src/ecg_morphological_extremum_detector.sv -----
// ECG extremum detector: sample store, shared window max/min scanner,
// transform and extremum decision. Depends on emd_pkg and the macro header.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid / in_stall     | in_sample
//  out     | output    | out_valid / out_stall   | status, extremum fields, slot
//  cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each sample runs through the accept state, then three window scans of
// 2*HALF_WINDOW+2 reads through the single store read port, each plus a pipeline
// step and a transform step, then the decision state.
// After reset a clearing pass zeroes the store; in_stall is high meanwhile. A new
// sample is taken while a result waits in the output register; the decision
// cycle holds until that register is free.
`default_nettype none

`include "ecg_morphological_extremum_detector_macros.svh"

module ecg_morphological_extremum_detector #(
  parameter int STORE_DEPTH = emd_pkg::STORE_DEPTH_D,
  parameter int RING_DEPTH  = emd_pkg::RING_DEPTH_D,
  parameter int HALF_WINDOW = emd_pkg::HALF_WINDOW_D,
  parameter int LOOK_BACK   = emd_pkg::LOOK_BACK_D,
  parameter int LAP_MODULUS = emd_pkg::LAP_MODULUS_D
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [emd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [emd_pkg::STAT_W-1:0]               out_status,
  output logic [emd_pkg::POS_W-1:0]                out_extremum_position,
  output logic [emd_pkg::LAP_W-1:0]                out_extremum_lap,
  output logic signed [emd_pkg::XF_W-1:0]          out_extremum_value,
  output logic                                     out_extremum_is_max,
  output logic [emd_pkg::SLOT_W-1:0]               out_ring_slot,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [emd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [emd_pkg::THR_W-1:0]           cfg_data
);
  import emd_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int RW    = $clog2(RING_DEPTH);
  localparam int LW    = $clog2(LAP_MODULUS);
  localparam int NREAD = 2 * HALF_WINDOW + 2;
  localparam int CW    = $clog2(NREAD + 1);

  localparam logic [AW:0]   DEPTH_C  = (AW+1)'(STORE_DEPTH);
  localparam logic [AW:0]   LB_OFF   = (AW+1)'(STORE_DEPTH - (LOOK_BACK % STORE_DEPTH));
  localparam logic [AW:0]   HW_OFF   = (AW+1)'(STORE_DEPTH - (HALF_WINDOW % STORE_DEPTH));
  localparam logic [AW:0]   ONE_C    = (AW+1)'(1);
  localparam logic [AW-1:0] LAST_IDX = AW'(STORE_DEPTH - 1);
  localparam logic [CW-1:0] NREAD_C  = CW'(NREAD);
  localparam logic [LW-1:0] LAP_LAST = LW'(LAP_MODULUS - 1);
  localparam logic [RW-1:0] RING_LAST = RW'(RING_DEPTH - 1);

  // a < depth, b <= depth
  function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + b;
    if (s >= DEPTH_C) s = s - DEPTH_C;
    return s[AW-1:0];
  endfunction

  function automatic logic [LW-1:0] lap_inc(input logic [LW-1:0] v);
    return (v == LAP_LAST) ? '0 : v + LW'(1);
  endfunction

  function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] v);
    return (v == RING_LAST) ? '0 : v + RW'(1);
  endfunction

  state_t state_r, state_nxt;

  logic [THR_W-1:0] peak_thr_r, wave_thr_r;

  logic [SAMPLE_W-1:0]        store_mem [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]              rd_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [SAMPLE_W-1:0]        mem_wdata;

  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] wp_r;
  logic [LW-1:0] lap_r;
  logic [RW-1:0] ring_idx_r;
  logic          learning_r;
  logic signed [XF_W-1:0] plat_prev_r;

  logic [AW-1:0] c_r, start_r, pos_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    cidx_r;
  logic signed [SAMPLE_W-1:0] x_r, mx_r, mn_r;
  logic signed [XF_W-1:0]     a_r, b_r, e_r;

  logic in_acc, load_out;
  logic [AW-1:0] wp_inc, j_new;
  logic [AW:0]   rd_off;

  // transform
  logic signed [14:0] dsum;
  logic signed [18:0] dext, prod;
  logic signed [XF_W-1:0] xf_val;

  // decision
  logic [XF_W-1:0] mag;
  logic passes, strict_ext, plat_end, is_max, found, learn_nxt;
  logic [LW-1:0] lap_sel;
  logic [RW-1:0] ring_nxt;
  logic [AW+POS_W-1:0] pos_ext;
  logic [LW+LAP_W-1:0] lap_ext;
  logic [RW+SLOT_W-1:0] slot_ext;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign wp_inc    = add_mod(wp_r, ONE_C);
  assign j_new     = add_mod(wp_inc, LB_OFF);
  assign rd_off    = (AW+1)'(cnt_r) - ONE_C;
  assign rd_addr   = (cnt_r == '0) ? c_r : add_mod(start_r, rd_off);

  always_comb begin
    dsum   = {{3{mx_r[SAMPLE_W-1]}}, mx_r} + {{3{mn_r[SAMPLE_W-1]}}, mn_r}
           - {{2{x_r[SAMPLE_W-1]}}, x_r, 1'b0};
    dext   = {{4{dsum[14]}}, dsum};
    prod   = (dext <<< 3) + (dext <<< 1);
    xf_val = prod[17:4];
  end

  always_comb begin
    mag        = b_r[XF_W-1] ? -b_r : b_r;
    passes     = (mag > {1'b0, peak_thr_r}) || (mag > {1'b0, wave_thr_r});
    strict_ext = ((b_r > e_r && b_r > a_r) || (b_r < e_r && b_r < a_r)) && passes;
    plat_end   = (b_r == a_r) && ((plat_prev_r < b_r && b_r > e_r) ||
                                  (plat_prev_r > b_r && b_r < e_r)) && passes;
    found      = strict_ext || plat_end;
    is_max     = strict_ext ? (b_r > e_r && b_r > a_r) : (plat_prev_r < b_r && b_r > e_r);
    lap_sel    = (pos_r != '0) ? lap_r : lap_inc(lap_r);
    ring_nxt   = ring_inc(ring_idx_r);
    learn_nxt  = learning_r && (ring_nxt != '0);
    pos_ext    = {{POS_W{1'b0}}, pos_r};
    lap_ext    = {{LAP_W{1'b0}}, lap_sel};
    slot_ext   = {{SLOT_W{1'b0}}, ring_idx_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == NREAD_C) state_nxt = ST_XFORM;
      ST_XFORM:  state_nxt = (cidx_r == 2'd2) ? ST_DECIDE : ST_SCAN;
      ST_DECIDE: if (!out_valid || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = in_sample;
    load_out  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        mem_we   = in_valid;
      end
      ST_DECIDE: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      peak_thr_r  <= PEAK_THR_RST;
      wave_thr_r  <= WAVE_THR_RST;
      wp_r        <= '0;
      lap_r       <= '0;
      ring_idx_r  <= '0;
      learning_r  <= 1'b1;
      plat_prev_r <= '0;
      out_valid   <= 1'b0;
      cnt_r       <= '0;
      cidx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PEAK_THR: peak_thr_r <= cfg_data;
          REG_WAVE_THR: wave_thr_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_acc) begin
        wp_r    <= wp_inc;
        c_r     <= j_new;
        start_r <= add_mod(j_new, HW_OFF);
        cnt_r   <= '0;
        cidx_r  <= '0;
        if (j_new == '0) lap_r <= lap_inc(lap_r);
      end
      if (state_r == ST_SCAN) begin
        cnt_r <= (cnt_r == NREAD_C) ? '0 : cnt_r + CW'(1);
        if (cnt_r == CW'(1)) begin
          x_r <= rd_data_r;
        end else if (cnt_r == CW'(2)) begin
          mx_r <= rd_data_r;
          mn_r <= rd_data_r;
        end else if (cnt_r > CW'(2)) begin
          if (rd_data_r > mx_r) mx_r <= rd_data_r;
          if (rd_data_r < mn_r) mn_r <= rd_data_r;
        end
      end
      if (state_r == ST_XFORM) begin
        case (cidx_r)
          2'd0:    a_r <= xf_val;
          2'd1:    b_r <= xf_val;
          default: e_r <= xf_val;
        endcase
        if (cidx_r == 2'd0) pos_r <= add_mod(c_r, ONE_C);
        cidx_r  <= cidx_r + 2'd1;
        c_r     <= add_mod(c_r, ONE_C);
        start_r <= add_mod(start_r, ONE_C);
      end
      if (load_out) begin
        if (b_r == e_r && b_r != a_r && passes) plat_prev_r <= a_r;
        if (found) begin
          ring_idx_r <= ring_nxt;
          learning_r <= learn_nxt;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (found) begin
        out_status            <= learn_nxt ? STAT_LEARN : STAT_READY;
        out_extremum_position <= pos_ext[POS_W-1:0];
        out_extremum_lap      <= lap_ext[LAP_W-1:0];
        out_extremum_value    <= b_r;
        out_extremum_is_max   <= is_max;
        out_ring_slot         <= slot_ext[SLOT_W-1:0];
      end else begin
        out_status            <= STAT_NONE;
        out_extremum_position <= '0;
        out_extremum_lap      <= '0;
        out_extremum_value    <= '0;
        out_extremum_is_max   <= 1'b0;
        out_ring_slot         <= '0;
      end
    end
  end

  `EMD_ASSERT(a_scan_bound, state_r == ST_SCAN |-> cnt_r <= NREAD_C, "scan counter overrun")
  `EMD_ASSERT(a_learn_wrap, $fell(learning_r) |-> ring_idx_r == '0, "learning cleared off wrap")
  `EMD_ASSERT(a_ring_step, !$stable(ring_idx_r) |-> $past(load_out), "ring index moved without result")
  `EMD_ASSERT(a_none_clean, out_valid && out_status == STAT_NONE |-> out_ring_slot == '0 && out_extremum_value == '0, "empty result not cleared")

endmodule

`default_nettype wire
